// ===== sv/piece_counting_scale_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Piece-counting scale: assertion macros
// Shared property wrappers, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PIECE_COUNTING_SCALE_UNIT_DEFINES_SVH
`define PIECE_COUNTING_SCALE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Piece-counting scale: shared package
// Payload types, key codes, widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int WEIGHT_W             = 16;
    localparam int COUNT_W              = 15;
    localparam int FACTOR_W             = 32;
    localparam int SCALE_SHIFT_DEFAULT  = 10;

    localparam logic [1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [1:0] KIND_KEY     = 2'd1;
    localparam logic [1:0] KIND_REMOTE  = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] KEY_CLEAR    = 8'h2A;
    localparam logic [7:0] KEY_COMMIT   = 8'h23;

    localparam logic [COUNT_W-1:0] ENTRY_MAX = 15'd32767;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [WEIGHT_W-1:0] weight;
        logic [7:0]                 key_code;
        logic [COUNT_W-1:0]         remote_count;
    } pcs_in_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] shown_value;
        logic                       counting;
        logic                       error;
    } pcs_out_t;

    typedef struct packed {
        logic load;        // capture the accepted request
        logic apply;       // perform the mode, entry and weight update
        logic div_start;   // launch the divider
        logic div_commit;  // divider operands: entry count instead of factor
        logic commit_wr;   // store the new factor and enter counting mode
        logic count_wr;    // store the saturated item count
        logic out_load;    // move the result into the output register
    } pcs_cmd_t;

    typedef struct packed {
        logic commit_req;
        logic mode_after;
        logic div_busy;
        logic div_done;
    } pcs_stat_t;

endpackage

// ===== sv/pcs_div.sv =====
// ----------------------------------------------------------------------------
// Piece-counting scale: signed divider
// Restoring radix-2 divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_div #(
    parameter int DIVIDEND_W = pcs_pkg::WEIGHT_W + pcs_pkg::SCALE_SHIFT_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [DIVIDEND_W-1:0]         dividend,
    input  logic signed [pcs_pkg::FACTOR_W-1:0]  divisor,
    output logic                                 busy,
    output logic                                 done,
    output logic [DIVIDEND_W-1:0]                quo_mag,
    output logic                                 quo_neg
);
    import pcs_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [FACTOR_W-1:0]   rem_reg;
    logic [FACTOR_W-1:0]   den_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVIDEND_W-1:0] a_u;
    logic [DIVIDEND_W-1:0] a_mag;
    logic [FACTOR_W-1:0]   b_u;
    logic [FACTOR_W-1:0]   b_mag;
    logic [FACTOR_W:0]     trial;
    logic [FACTOR_W:0]     diff;
    logic                  fits;

    always_comb begin
        a_u   = dividend;
        b_u   = divisor;
        a_mag = a_u[DIVIDEND_W-1] ? (~a_u + DIVIDEND_W'(1)) : a_u;
        b_mag = b_u[FACTOR_W-1] ? (~b_u + FACTOR_W'(1)) : b_u;
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= a_mag;
            rem_reg <= '0;
            den_reg <= b_mag;
            neg_reg <= a_u[DIVIDEND_W-1] ^ b_u[FACTOR_W-1];
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign quo_mag = quo_reg;
    assign quo_neg = neg_reg;

endmodule

// ===== sv/pcs_dp.sv =====
// ----------------------------------------------------------------------------
// Piece-counting scale: datapath
// Holds the scale state, decodes requests and forms the result.
// ----------------------------------------------------------------------------
module pcs_dp #(
    parameter int SCALE_SHIFT = pcs_pkg::SCALE_SHIFT_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pcs_pkg::pcs_in_t   s_data,
    input  pcs_pkg::pcs_cmd_t  cmd,
    output pcs_pkg::pcs_stat_t st,
    output pcs_pkg::pcs_out_t  m_data
);
    import pcs_pkg::*;

    localparam int PROD_W = WEIGHT_W + SCALE_SHIFT;

    pcs_in_t                    in_reg;
    pcs_out_t                   out_reg;
    logic                       mode_reg;
    logic [COUNT_W-1:0]         entry_reg;
    logic signed [WEIGHT_W-1:0] lw_reg;
    logic [FACTOR_W-1:0]        factor_reg;
    logic signed [WEIGHT_W-1:0] shown_reg;
    logic                       err_reg;

    logic                       mode_next;
    logic [COUNT_W-1:0]         entry_next;
    logic signed [WEIGHT_W-1:0] lw_next;
    logic                       commit_req;
    logic                       err_apply;

    logic                       is_digit;
    logic [3:0]                 digit;
    logic [COUNT_W+3:0]         digit_sum;
    logic [COUNT_W-1:0]         digit_sat;

    logic signed [PROD_W-1:0]   dividend;
    logic signed [FACTOR_W-1:0] divisor;
    logic                       div_busy;
    logic                       div_done;
    logic [PROD_W-1:0]          quo_mag;
    logic                       quo_neg;

    logic [PROD_W-1:0]          mag_neg;
    logic [FACTOR_W-1:0]        mag_wide;
    logic [FACTOR_W-1:0]        factor_new;
    logic signed [WEIGHT_W-1:0] count_val;
    logic                       count_err;

    // Decimal entry: entry * 10 + digit, clamped to the largest count.
    always_comb begin
        is_digit  = (in_reg.key_code >= ASCII_ZERO) && (in_reg.key_code <= ASCII_NINE);
        digit     = 4'(in_reg.key_code - ASCII_ZERO);
        digit_sum = {entry_reg, 3'b000} + {2'b00, entry_reg, 1'b0}
                  + (COUNT_W + 4)'(digit);
        digit_sat = (digit_sum > (COUNT_W + 4)'(ENTRY_MAX)) ? ENTRY_MAX
                                                          : digit_sum[COUNT_W-1:0];
    end

    always_comb begin
        lw_next    = lw_reg;
        entry_next = entry_reg;
        mode_next  = mode_reg;
        commit_req = 1'b0;
        err_apply  = 1'b0;
        unique case (in_reg.kind)
            KIND_WEIGHT: begin
                lw_next = in_reg.weight;
            end
            KIND_RESTART: begin
                mode_next  = 1'b0;
                entry_next = '0;
            end
            KIND_KEY: begin
                if (!mode_reg) begin
                    priority if (is_digit) begin
                        entry_next = digit_sat;
                    end else if (in_reg.key_code == KEY_CLEAR) begin
                        entry_next = '0;
                    end else if (in_reg.key_code == KEY_COMMIT && entry_reg != '0) begin
                        commit_req = 1'b1;
                    end else begin
                        // Any other key leaves the entry alone.
                        entry_next = entry_reg;
                    end
                end
            end
            KIND_REMOTE: begin
                if (!mode_reg) begin
                    if (in_reg.remote_count == '0) begin
                        err_apply = 1'b1;
                    end else begin
                        commit_req = 1'b1;
                        entry_next = in_reg.remote_count;
                    end
                end
            end
        endcase
    end

    // The commit divides by the entered count, counting divides by the factor.
    always_comb begin
        dividend = {lw_reg, {SCALE_SHIFT{1'b0}}};
        divisor  = cmd.div_commit ? FACTOR_W'(entry_reg) : factor_reg;
    end

    pcs_div #(
        .DIVIDEND_W (PROD_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quo_mag  (quo_mag),
        .quo_neg  (quo_neg)
    );

    // Signed quotient, truncated toward zero: kept whole as the new factor, clamped to 16 bits as the count.
    always_comb begin
        mag_neg    = ~quo_mag + PROD_W'(1);
        mag_wide   = FACTOR_W'(quo_mag);
        factor_new = quo_neg ? (~mag_wide + FACTOR_W'(1)) : mag_wide;
        count_err  = 1'b0;
        priority if (factor_reg == '0) begin
            count_val = '0;
            count_err = 1'b1;
        end else if (quo_neg && quo_mag > PROD_W'(32768)) begin
            count_val = 16'sh8000;
            count_err = 1'b1;
        end else if (quo_neg) begin
            count_val = mag_neg[WEIGHT_W-1:0];
        end else if (quo_mag > PROD_W'(32767)) begin
            count_val = 16'sh7FFF;
            count_err = 1'b1;
        end else begin
            count_val = quo_mag[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            entry_reg  <= '0;
            lw_reg     <= '0;
            factor_reg <= '0;
        end else if (cmd.apply) begin
            mode_reg  <= mode_next;
            entry_reg <= entry_next;
            lw_reg    <= lw_next;
        end else if (cmd.commit_wr) begin
            mode_reg   <= 1'b1;
            factor_reg <= factor_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.apply) begin
            shown_reg <= {1'b0, entry_next};
            err_reg   <= err_apply;
        end else if (cmd.count_wr) begin
            shown_reg <= count_val;
            err_reg   <= err_reg | count_err;
        end
        if (cmd.out_load) begin
            out_reg.shown_value <= shown_reg;
            out_reg.counting    <= mode_reg;
            out_reg.error       <= err_reg;
        end
    end

    always_comb begin
        st.commit_req = commit_req;
        st.mode_after = mode_next;
        st.div_busy   = div_busy;
        st.div_done   = div_done;
    end

    assign m_data = out_reg;

endmodule

// ===== sv/pcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Piece-counting scale: controller
// Sequences decode, commit division, count division and result hand-off.
// ----------------------------------------------------------------------------
`include "piece_counting_scale_unit_defines.svh"

module pcs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  pcs_pkg::pcs_stat_t st,
    output pcs_pkg::pcs_cmd_t  cmd
);
    import pcs_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_APPLY   = 3'd1;
    localparam logic [2:0] ST_START_C = 3'd2;
    localparam logic [2:0] ST_WAIT_C  = 3'd3;
    localparam logic [2:0] ST_START_N = 3'd4;
    localparam logic [2:0] ST_WAIT_N  = 3'd5;
    localparam logic [2:0] ST_FIN     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
                priority if (st.commit_req) begin
                    state_next = ST_START_C;
                end else if (st.mode_after) begin
                    state_next = ST_START_N;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_START_C: begin
                cmd.div_start  = 1'b1;
                cmd.div_commit = 1'b1;
                state_next     = ST_WAIT_C;
            end
            ST_WAIT_C: begin
                if (st.div_done) begin
                    cmd.commit_wr = 1'b1;
                    state_next    = ST_START_N;
                end
            end
            ST_START_N: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_N;
            end
            ST_WAIT_N: begin
                if (st.div_done) begin
                    cmd.count_wr = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN: begin
                // The output register may still hold the previous result.
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg & ~m_ready;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    `PCS_ASSERT_IMP(a_wait_has_divider, (state_reg == ST_WAIT_C || state_reg == ST_WAIT_N), (st.div_busy || st.div_done), "Waiting for a quotient while the divider is idle.")
    `PCS_ASSERT_IMP(a_done_when_waiting, st.div_done, (state_reg == ST_WAIT_C || state_reg == ST_WAIT_N), "Divider finished outside a wait state.")
    `PCS_ASSERT_IMP(a_result_from_fin, $rose(out_valid_reg), ($past(state_reg) == ST_FIN), "Result appeared without passing the final state.")
    `PCS_ASSERT_NXT(a_commit_then_count, (state_reg == ST_WAIT_C && st.div_done), (state_reg == ST_START_N), "A commit was not followed by a count division.")

endmodule

// ===== sv/piece_counting_scale_unit.sv =====
// A request in calibrating mode or a restart needs no division, a counting request
// runs one count division and a commit runs the commit division, then a count division.
// Throughput: one request at a time; the bit-serial divider, one quotient bit per
// cycle over WEIGHT_W + SCALE_SHIFT bits, sets the cost of each division.
// Reset (aresetn low, synchronous): calibrating mode, zero entry, weight and factor.
// ----------------------------------------------------------------------------
// Piece-counting scale unit
// Keypad or remote calibration of a per-piece weight factor, then item counts.
// ----------------------------------------------------------------------------
module piece_counting_scale_unit #(
    parameter int SCALE_SHIFT = pcs_pkg::SCALE_SHIFT_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcs_pkg::pcs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pcs_pkg::pcs_out_t m_data
);
    import pcs_pkg::*;

    pcs_cmd_t  cmd;
    pcs_stat_t st;

    pcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    pcs_dp #(
        .SCALE_SHIFT (SCALE_SHIFT)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st),
        .m_data  (m_data)
    );

endmodule
